// ----- rtl/siq_pkg.sv -----
// shared constants, types and codes for the sorted insert queue
package siq_pkg;

    // queue geometry
    localparam int DEPTH     = 16;
    localparam int ID_WIDTH  = 16;
    localparam int KEY_WIDTH = 16;
    localparam int CNT_W     = $clog2(DEPTH + 1);

    // command and status widths
    localparam int FUNC_W    = 2;
    localparam int STATUS_W  = 2;

    // command codes
    localparam logic [FUNC_W-1:0] FN_PUSH   = 2'd0;
    localparam logic [FUNC_W-1:0] FN_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] FN_POP    = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_POP_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL_DROP = 2'd2;

    // input tdata layout
    localparam int IN_ID_LSB  = 0;
    localparam int IN_KEY_LSB = IN_ID_LSB + ID_WIDTH;
    localparam int IN_USED_W  = IN_KEY_LSB + KEY_WIDTH;
    localparam int IN_DATA_W  = ((IN_USED_W + 7) / 8) * 8;

    // output tdata layout
    localparam int OUT_ID_LSB     = 0;
    localparam int OUT_KEY_LSB    = OUT_ID_LSB + ID_WIDTH;
    localparam int OUT_EMPTY_BIT  = OUT_KEY_LSB + KEY_WIDTH;
    localparam int OUT_CNT_LSB    = OUT_EMPTY_BIT + 1;
    localparam int OUT_STATUS_LSB = OUT_CNT_LSB + CNT_W;
    localparam int OUT_USED_W     = OUT_STATUS_LSB + STATUS_W;
    localparam int OUT_DATA_W     = ((OUT_USED_W + 7) / 8) * 8;

    // one queue entry
    typedef struct packed {
        logic [ID_WIDTH-1:0]  id;
        logic [KEY_WIDTH-1:0] key;
    } t_entry;

    // command broadcast to every cell
    typedef struct packed {
        logic   ins;     // place new entry and shift the rest back
        logic   by_key;  // placement follows key order, else tail
        logic   pop;     // shift everything one cell toward the head
        t_entry entry;   // entry being placed
    } t_cell_ctl;

endpackage

// ----- rtl/siq_cell.sv -----
// one storage cell of the shift-register queue
module siq_cell (
    input  logic              i_clk,
    input  siq_pkg::t_cell_ctl i_ctl,
    input  logic              i_valid,   // cell holds a live entry
    input  logic              i_found,   // placement slot lies ahead of this cell
    input  siq_pkg::t_entry   i_left,    // neighbor nearer the head
    input  siq_pkg::t_entry   i_right,   // neighbor nearer the tail
    output siq_pkg::t_entry   o_entry,
    output siq_pkg::t_entry   o_next,
    output logic              o_found
);
    import siq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;
    logic   w_pass;
    logic   w_place;

    // new entry goes behind every live entry that passes (tail mode: all live)
    assign w_pass  = i_valid && (!i_ctl.by_key || (r_entry.key > i_ctl.entry.key));
    assign w_place = !i_found && !w_pass;
    assign o_found = i_found || !w_pass;

    // next content: placed entry, shift back, shift forward or hold
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins) begin
            if (w_place) begin
                n_entry = i_ctl.entry;
            end else if (i_found) begin
                n_entry = i_left;
            end
        end else if (i_ctl.pop) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_next  = n_entry;

endmodule

// ----- rtl/sorted_insert_queue_core.sv -----
// Sorted insert queue: a row of DEPTH cells, cell 0 the head, that takes one command item
// per clock (push at tail, insert by descending points, pop head) and returns one result
// item per command with the head after the command, an empty flag, the fill count and a
// status. A command completes in the cycle it is accepted: every cell compares its key with
// the new key at once and a one-bit placement flag ripples down the row of cells, so the
// whole queue updates together. The result is loaded into an output register on
// acceptance; s_axis_tready stays high while that register is empty or being drained, so a
// new item is taken in every cycle unless the result side stalls.
module sorted_insert_queue_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // command items
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [siq_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // item_id, item_points
    input  logic [siq_pkg::FUNC_W-1:0]      s_axis_tuser,  // func
    // result items
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [siq_pkg::OUT_DATA_W-1:0]  m_axis_tdata   // head_id, head_points, is_empty,
                                                           // fill_count, status
);
    import siq_pkg::*;

    logic [CNT_W-1:0]    r_occ;
    logic [CNT_W-1:0]    n_occ;
    logic                r_out_valid;
    logic [ID_WIDTH-1:0]  r_head_id;
    logic [KEY_WIDTH-1:0] r_head_key;
    logic                r_empty;
    logic [CNT_W-1:0]    r_cnt;
    logic [STATUS_W-1:0] r_status;
    logic [STATUS_W-1:0] n_status;

    logic      w_accept;
    logic      w_full;
    logic      w_none;
    t_cell_ctl w_ctl;
    t_entry    w_zero;
    t_entry    w_entry [DEPTH];
    t_entry    w_next  [DEPTH];
    logic      w_valid [DEPTH];
    logic      w_found [DEPTH+1];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_full        = (r_occ == CNT_W'(DEPTH));
    assign w_none        = (r_occ == '0);
    assign w_zero        = '0;

    // decode the command into cell controls, next count and status
    always_comb begin
        w_ctl.ins       = 1'b0;
        w_ctl.by_key    = 1'b0;
        w_ctl.pop       = 1'b0;
        w_ctl.entry.id  = s_axis_tdata[IN_ID_LSB +: ID_WIDTH];
        w_ctl.entry.key = s_axis_tdata[IN_KEY_LSB +: KEY_WIDTH];
        n_occ           = r_occ;
        n_status        = ST_OK;
        unique case (s_axis_tuser)
            FN_PUSH, FN_INSERT: begin
                if (w_full) begin
                    n_status = ST_FULL_DROP;
                end else begin
                    w_ctl.ins    = w_accept;
                    w_ctl.by_key = (s_axis_tuser == FN_INSERT);
                    n_occ        = r_occ + CNT_W'(1);
                end
            end
            FN_POP: begin
                if (w_none) begin
                    n_status = ST_POP_EMPTY;
                end else begin
                    w_ctl.pop = w_accept;
                    n_occ     = r_occ - CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // row of cells with the placement flag rippling from the head
    assign w_found[0] = 1'b0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_entry w_left;
        t_entry w_right;

        assign w_valid[g] = (r_occ > CNT_W'(g));

        if (g == 0) begin : g_head
            assign w_left = w_ctl.entry;
        end else begin : g_mid
            assign w_left = w_entry[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right = w_zero;
        end else begin : g_body
            assign w_right = w_entry[g+1];
        end

        siq_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_valid (w_valid[g]),
            .i_found (w_found[g]),
            .i_left  (w_left),
            .i_right (w_right),
            .o_entry (w_entry[g]),
            .o_next  (w_next[g]),
            .o_found (w_found[g+1])
        );
    end

    // fill count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_occ <= n_occ;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, head taken from cell 0 after the command
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_empty  <= (n_occ == '0);
            r_cnt    <= n_occ;
            r_status <= n_status;
            if (n_occ == '0) begin
                r_head_id  <= '0;
                r_head_key <= '0;
            end else begin
                r_head_id  <= w_next[0].id;
                r_head_key <= w_next[0].key;
            end
        end
    end

    // pack the result item
    always_comb begin
        m_axis_tdata                                   = '0;
        m_axis_tdata[OUT_ID_LSB +: ID_WIDTH]           = r_head_id;
        m_axis_tdata[OUT_KEY_LSB +: KEY_WIDTH]         = r_head_key;
        m_axis_tdata[OUT_EMPTY_BIT]                    = r_empty;
        m_axis_tdata[OUT_CNT_LSB +: CNT_W]             = r_cnt;
        m_axis_tdata[OUT_STATUS_LSB +: STATUS_W]       = r_status;
    end

    assign m_axis_tvalid = r_out_valid;

endmodule

// ----- rtl/siq_checker.sv -----
// port-level checks for the sorted insert queue, bound to the top level
module siq_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [siq_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input logic [siq_pkg::FUNC_W-1:0]      s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [siq_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import siq_pkg::*;

    logic                w_empty;
    logic [CNT_W-1:0]    w_cnt;
    logic [STATUS_W-1:0] w_status;
    logic                w_head_zero;

    assign w_empty     = m_axis_tdata[OUT_EMPTY_BIT];
    assign w_cnt       = m_axis_tdata[OUT_CNT_LSB +: CNT_W];
    assign w_status    = m_axis_tdata[OUT_STATUS_LSB +: STATUS_W];
    assign w_head_zero = (m_axis_tdata[OUT_ID_LSB +: ID_WIDTH] == '0) &&
                         (m_axis_tdata[OUT_KEY_LSB +: KEY_WIDTH] == '0);

    // no result item right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // empty flag matches count and empty queue reports a zero head
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_empty == (w_cnt == '0)) && (!w_empty || w_head_zero))
        else $error("empty flag, count and head disagree");

    // count stays within the queue size
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> w_cnt <= CNT_W'(DEPTH))
        else $error("fill count beyond depth");

    // pop error only on empty, drop error only on full
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_status != ST_POP_EMPTY || w_empty) &&
                          (w_status != ST_FULL_DROP || w_cnt == CNT_W'(DEPTH)))
        else $error("status inconsistent with fill count");

endmodule

bind sorted_insert_queue_core siq_checker u_siq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- verif/testbench.sv -----
// self-checking testbench for the sorted insert queue core
module testbench;
    import siq_pkg::*;

    // unused command code, the queue reports its state unchanged
    localparam logic [FUNC_W-1:0] FN_NOP = 2'd3;
    localparam int RANDOM_ITEMS = 2000;
    localparam int CYCLE_LIMIT  = 500000;

    // what one result item reports
    typedef struct {
        logic [ID_WIDTH-1:0]  head_id;
        logic [KEY_WIDTH-1:0] head_points;
        logic                 is_empty;
        logic [CNT_W-1:0]     fill_count;
        logic [STATUS_W-1:0]  status;
    } t_queue_view;

    // shadow copy of the queue and the views it should report, oldest first
    class queue_scoreboard;
        logic [ID_WIDTH-1:0]  ids [DEPTH];
        logic [KEY_WIDTH-1:0] keys [DEPTH];
        int                   fill = 0;
        int                   errors = 0;
        t_queue_view          views_due [$];

        function void note_command(logic [FUNC_W-1:0] func, logic [ID_WIDTH-1:0] id,
                                   logic [KEY_WIDTH-1:0] key);
            t_queue_view v;
            int pos;
            int i;
            v.status = ST_OK;
            if (func == FN_PUSH || func == FN_INSERT) begin
                if (fill >= DEPTH) begin
                    v.status = ST_FULL_DROP;
                end else begin
                    pos = fill;
                    // ties go ahead of older entries with equal points
                    if (func == FN_INSERT) begin
                        pos = 0;
                        while (pos < fill && keys[pos] > key) pos++;
                    end
                    for (i = fill; i > pos; i--) begin
                        ids[i]  = ids[i-1];
                        keys[i] = keys[i-1];
                    end
                    ids[pos]  = id;
                    keys[pos] = key;
                    fill++;
                end
            end else if (func == FN_POP) begin
                if (fill == 0) begin
                    v.status = ST_POP_EMPTY;
                end else begin
                    for (i = 0; i + 1 < fill; i++) begin
                        ids[i]  = ids[i+1];
                        keys[i] = keys[i+1];
                    end
                    fill--;
                end
            end
            v.is_empty    = (fill == 0);
            v.head_id     = (fill == 0) ? '0 : ids[0];
            v.head_points = (fill == 0) ? '0 : keys[0];
            v.fill_count  = CNT_W'(fill);
            views_due.push_back(v);
        endfunction

        function int pending();
            return views_due.size();
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] d);
            t_queue_view want;
            t_queue_view got;
            got.head_id     = d[OUT_ID_LSB +: ID_WIDTH];
            got.head_points = d[OUT_KEY_LSB +: KEY_WIDTH];
            got.is_empty    = d[OUT_EMPTY_BIT];
            got.fill_count  = d[OUT_CNT_LSB +: CNT_W];
            got.status      = d[OUT_STATUS_LSB +: STATUS_W];
            if (views_due.size() == 0) begin
                $error("result item with no command waiting: %h", d);
                errors++;
                return;
            end
            want = views_due.pop_front();
            if (got.head_id !== want.head_id) begin
                $error("head_id expected %0h actual %0h", want.head_id, got.head_id);
                errors++;
            end
            if (got.head_points !== want.head_points) begin
                $error("head_points expected %0h actual %0h", want.head_points,
                       got.head_points);
                errors++;
            end
            if (got.is_empty !== want.is_empty) begin
                $error("is_empty expected %0b actual %0b", want.is_empty, got.is_empty);
                errors++;
            end
            if (got.fill_count !== want.fill_count) begin
                $error("fill_count expected %0d actual %0d", want.fill_count,
                       got.fill_count);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status expected %0d actual %0d", want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // item_id, item_points
    logic [FUNC_W-1:0]     s_axis_tuser = FN_NOP; // func
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // head_id, head_points, is_empty,
                                                // fill_count, status

    queue_scoreboard sb = new;
    bit              calm = 1'b0;
    int              cycles = 0;

    sorted_insert_queue_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // idle length: mostly none, some short, a few long
    function int idle_len();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // result side back-pressure
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                m_axis_tready = 1'b0;
                stall--;
            end else begin
                m_axis_tready = 1'b1;
                stall = idle_len();
            end
        end
    end

    // check every accepted result item
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    // run limit
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    // drive one command item and wait for its acceptance
    task automatic send_command(logic [FUNC_W-1:0] func, logic [ID_WIDTH-1:0] id,
                                logic [KEY_WIDTH-1:0] key);
        int gap;
        gap = idle_len();
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = func;
        s_axis_tdata  = {key, id};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_command(func, id, key);
    endtask

    // hold off the sender until every result item has come back
    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // points: often a few values for ties, sometimes the extremes
    function logic [KEY_WIDTH-1:0] pick_points();
        case ($urandom_range(0, 3))
            0: return KEY_WIDTH'($urandom_range(0, 3));
            1: return $urandom_range(0, 1) ? '1 : '0;
            default: return KEY_WIDTH'($urandom);
        endcase
    endfunction

    initial begin
        int sent;
        int burst;
        int mode;
        int r;
        logic [FUNC_W-1:0] func;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty queue cases, extremes, ties, full queue
        send_command(FN_POP, 16'h1234, 16'h5678);
        send_command(FN_NOP, 16'hffff, 16'hffff);
        send_command(FN_PUSH, 16'h0000, 16'h0000);
        send_command(FN_INSERT, 16'hffff, 16'hffff);
        send_command(FN_INSERT, 16'h0001, 16'h0000);
        send_command(FN_INSERT, 16'h0002, 16'h8000);
        send_command(FN_INSERT, 16'h0003, 16'h8000);
        send_command(FN_NOP, 16'h0000, 16'h0000);
        send_command(FN_POP, 16'h0000, 16'h0000);
        for (int i = 0; i < 12; i++) begin
            send_command((i % 3 == 0) ? FN_PUSH : FN_INSERT, ID_WIDTH'(16'h1000 + i),
                         KEY_WIDTH'((i % 4) * 16'h4000));
        end
        send_command(FN_PUSH, 16'haaaa, 16'h5555);
        send_command(FN_INSERT, 16'h5555, 16'hffff);
        wait_drained();

        // random bursts: filling, draining or mixed, with pauses now and then
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            mode  = $urandom_range(0, 2);
            burst = $urandom_range(10, 40);
            calm  = ($urandom_range(0, 4) == 0);
            for (int k = 0; k < burst; k++) begin
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    func = FN_NOP;
                end else if (mode == 0) begin
                    func = (r < 75) ? (r[0] ? FN_PUSH : FN_INSERT) : FN_POP;
                end else if (mode == 1) begin
                    func = (r < 30) ? (r[0] ? FN_PUSH : FN_INSERT) : FN_POP;
                end else begin
                    func = (r < 66) ? ((r < 35) ? FN_INSERT : FN_PUSH) : FN_POP;
                end
                send_command(func, ID_WIDTH'($urandom), pick_points());
                sent++;
            end
            if ($urandom_range(0, 19) == 0) wait_drained();
        end
        calm = 1'b0;

        // let the last result items come out
        wait_drained();
        repeat (5) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/siq_pkg.sv
rtl/siq_cell.sv
rtl/sorted_insert_queue_core.sv
rtl/siq_checker.sv
verif/testbench.sv
